FILE: src/gaps_pkg.sv
package gaps_pkg;

    localparam int GRID_COLS  = 8;
    localparam int GRID_ROWS  = 8;
    localparam int NCELLS     = GRID_COLS * GRID_ROWS;
    localparam int OPEN_DEPTH = 256;
    localparam int CW         = 6;
    localparam int OW         = 8;
    localparam int OCW        = 9;

    localparam logic [6:0]  COST_INF = 7'h7f;
    localparam logic [15:0] EST_INF  = 16'hffff;
    localparam logic [15:0] EST_MAX  = 16'hfffe;

    localparam logic [2:0] DIR_NONE  = 3'd0;
    localparam logic [2:0] DIR_UP    = 3'd1;
    localparam logic [2:0] DIR_DOWN  = 3'd2;
    localparam logic [2:0] DIR_LEFT  = 3'd3;
    localparam logic [2:0] DIR_RIGHT = 3'd4;

    localparam logic REG_START = 1'b0;
    localparam logic REG_GOAL  = 1'b1;

    typedef enum logic [4:0] {
        ST_IDLE, ST_WIPE, ST_CLR, ST_INIT,
        ST_SORT_I, ST_SORT_RV, ST_SORT_WV, ST_SORT_RJ, ST_SORT_WJ, ST_SORT_CMP,
        ST_SORT_PUT,
        ST_SKIP_R, ST_SKIP_W, ST_SKIP_T,
        ST_SH_R, ST_SH_W,
        ST_EXP, ST_NB_R, ST_NB_W, ST_NB_D,
        ST_DUMP_R, ST_DUMP_W
    } t_state;

    typedef struct packed {
        logic       obst;
        logic       expd;
        logic [6:0] cost;
        logic [15:0] est;
        logic [2:0] par;
    } t_cell;

    // rounded euclidean distance in q.8 for |dx|,|dy| below 8
    function automatic logic [15:0] heur_q8(input logic [2:0] adx, input logic [2:0] ady);
        logic [15:0] t [64];
        t = '{16'd0,16'd256,16'd512,16'd768,16'd1024,16'd1280,16'd1536,16'd1792,
              16'd256,16'd362,16'd572,16'd810,16'd1056,16'd1305,16'd1557,16'd1810,
              16'd512,16'd572,16'd724,16'd923,16'd1145,16'd1379,16'd1619,16'd1864,
              16'd768,16'd810,16'd923,16'd1086,16'd1280,16'd1493,16'd1717,16'd1950,
              16'd1024,16'd1056,16'd1145,16'd1280,16'd1448,16'd1639,16'd1846,16'd2064,
              16'd1280,16'd1305,16'd1379,16'd1493,16'd1639,16'd1810,16'd1999,16'd2202,
              16'd1536,16'd1557,16'd1619,16'd1717,16'd1846,16'd1999,16'd2172,16'd2360,
              16'd1792,16'd1810,16'd1864,16'd1950,16'd2064,16'd2202,16'd2360,16'd2534};
        return t[{adx, ady}];
    endfunction

endpackage

FILE: src/grid_astar_path_search_unit.sv
// a* search on an 8x8 4-connected grid. after reset a pass over all 64 cells clears the
// obstacle map with busy high. a mode 0 request writes one obstacle bit.
// a mode 1 request clears the search fields of the cell store, runs the
// search, then streams 64 records (x outer, y inner) on o_valid, o_last on
// the final one. the search time is set by the insertion sort of the open
// list, which moves one element at a time in the open-list memory. results
// cannot be held off; busy stays high until the dump ends.
module grid_astar_path_search_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic       i_mode,
    input  logic [5:0] i_cell_req,
    input  logic       i_blocked,
    input  logic       i_cfg_we,
    input  logic       i_cfg_idx,
    input  logic [5:0] i_cfg_data,
    output logic       o_valid,
    output logic [2:0] o_cell_x,
    output logic [2:0] o_cell_y,
    output logic       o_is_obstacle,
    output logic       o_was_expanded,
    output logic [2:0] o_parent_dir,
    output logic       o_has_cost,
    output logic [5:0] o_path_cost,
    output logic       o_last
);

    localparam int CW  = gaps_pkg::CW;
    localparam int OW  = gaps_pkg::OW;
    localparam int OCW = gaps_pkg::OCW;

    // cell store (obstacle bit and search fields) and open list memories
    gaps_pkg::t_cell r_cell_mem [gaps_pkg::NCELLS];
    logic [CW-1:0]   r_open_mem [gaps_pkg::OPEN_DEPTH];
    gaps_pkg::t_cell r_crd;
    logic [CW-1:0]   r_ord;

    logic            c_we, o_we;
    logic [CW-1:0]   c_wa, c_ra;
    gaps_pkg::t_cell c_wd;
    logic [OW-1:0]   o_wa, o_ra;
    logic [CW-1:0]   o_wd;

    always_ff @(posedge i_clk) begin
        if (c_we) r_cell_mem[c_wa] <= c_wd;
        r_crd <= r_cell_mem[c_ra];
        if (o_we) r_open_mem[o_wa] <= o_wd;
        r_ord <= r_open_mem[o_ra];
    end

    gaps_pkg::t_state r_st, n_st;
    logic [CW-1:0]  r_start, r_goal;
    logic [OCW-1:0] r_cnt, n_cnt, r_i, n_i, r_j, n_j, r_k, n_k;
    logic [CW-1:0]  r_v, n_v, r_w, n_w, r_cur, n_cur, r_nb, n_nb;
    logic [15:0]    r_fv, n_fv;
    logic [6:0]     r_ccost, n_ccost;
    logic [1:0]     r_d, n_d;
    logic [CW-1:0]  r_idx, n_idx;
    logic           r_ov, n_ov;
    gaps_pkg::t_cell r_oc, n_oc;
    logic [CW-1:0]  r_oidx, n_oidx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= gaps_pkg::ST_WIPE;
            r_start <= 6'd4;
            r_goal <= 6'd10;
            r_ov <= 1'b0;
            r_idx <= '0;
        end else begin
            r_st <= n_st;
            r_ov <= n_ov;
            r_idx <= n_idx;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    gaps_pkg::REG_START: r_start <= i_cfg_data;
                    gaps_pkg::REG_GOAL:  r_start <= r_start;
                endcase
                if (i_cfg_idx == gaps_pkg::REG_GOAL) r_goal <= i_cfg_data;
            end
        end
        r_cnt <= n_cnt; r_i <= n_i; r_j <= n_j; r_k <= n_k;
        r_v <= n_v; r_w <= n_w; r_cur <= n_cur; r_nb <= n_nb;
        r_fv <= n_fv; r_ccost <= n_ccost; r_d <= n_d;
        r_oc <= n_oc; r_oidx <= n_oidx;
    end

    function automatic logic [15:0] est_of(input logic [CW-1:0] c, input logic [6:0] g,
                                           input logic [CW-1:0] goal);
        logic [2:0] ax, ay;
        logic [16:0] f;
        ax = (c[2:0] > goal[2:0]) ? c[2:0] - goal[2:0] : goal[2:0] - c[2:0];
        ay = (c[5:3] > goal[5:3]) ? c[5:3] - goal[5:3] : goal[5:3] - c[5:3];
        f = {2'b0, g, 8'b0} + {1'b0, gaps_pkg::heur_q8(ax, ay)};
        return (f > {1'b0, gaps_pkg::EST_MAX}) ? gaps_pkg::EST_MAX : f[15:0];
    endfunction

    logic       nb_ok;
    logic [CW-1:0] nb_c;
    logic [2:0] nb_dir;
    always_comb begin
        nb_ok = 1'b0; nb_c = r_cur; nb_dir = gaps_pkg::DIR_NONE;
        case (r_d)
            2'd0: begin nb_ok = r_cur[5:3] != 3'd0; nb_c = r_cur - 6'd8;
                        nb_dir = gaps_pkg::DIR_DOWN; end
            2'd1: begin nb_ok = r_cur[5:3] != 3'd7; nb_c = r_cur + 6'd8;
                        nb_dir = gaps_pkg::DIR_UP; end
            2'd2: begin nb_ok = r_cur[2:0] != 3'd0; nb_c = r_cur - 6'd1;
                        nb_dir = gaps_pkg::DIR_RIGHT; end
            default: begin nb_ok = r_cur[2:0] != 3'd7; nb_c = r_cur + 6'd1;
                        nb_dir = gaps_pkg::DIR_LEFT; end
        endcase
    end

    always_comb begin
        n_st = r_st; n_cnt = r_cnt; n_i = r_i; n_j = r_j; n_k = r_k;
        n_v = r_v; n_w = r_w; n_cur = r_cur; n_nb = r_nb; n_fv = r_fv;
        n_ccost = r_ccost; n_d = r_d; n_idx = r_idx;
        n_ov = 1'b0; n_oc = r_oc; n_oidx = r_oidx;
        c_we = 1'b0; c_wa = r_idx; c_wd = r_crd; c_ra = r_idx;
        o_we = 1'b0; o_wa = r_j[OW-1:0]; o_wd = r_v; o_ra = r_j[OW-1:0];
        unique case (r_st)
            gaps_pkg::ST_IDLE: begin
                if (start && !busy) begin
                    if (i_mode) begin
                        c_ra = '0; n_idx = '0; n_st = gaps_pkg::ST_CLR;
                    end else begin
                        // obstacle load, search fields are cleared anyway per search
                        c_we = 1'b1; c_wa = i_cell_req;
                        c_wd = '{obst: i_blocked, expd: 1'b0, cost: gaps_pkg::COST_INF,
                                 est: gaps_pkg::EST_INF, par: gaps_pkg::DIR_NONE};
                    end
                end
            end
            gaps_pkg::ST_WIPE: begin
                // after reset every cell is free
                c_we = 1'b1; c_wa = r_idx;
                c_wd = '{obst: 1'b0, expd: 1'b0, cost: gaps_pkg::COST_INF,
                         est: gaps_pkg::EST_INF, par: gaps_pkg::DIR_NONE};
                n_idx = r_idx + 6'd1;
                if (r_idx == 6'd63) n_st = gaps_pkg::ST_IDLE;
            end
            gaps_pkg::ST_CLR: begin
                // reset the search fields of every cell, keep the obstacle bit
                c_we = 1'b1; c_wa = r_idx;
                c_wd = '{obst: r_crd.obst, expd: 1'b0, cost: gaps_pkg::COST_INF,
                         est: gaps_pkg::EST_INF, par: gaps_pkg::DIR_NONE};
                c_ra = r_idx + 6'd1;
                n_idx = r_idx + 6'd1;
                if (r_idx == 6'd63) begin
                    c_ra = r_start; n_st = gaps_pkg::ST_INIT;
                end
            end
            gaps_pkg::ST_INIT: begin
                n_cur = r_start;
                c_we = 1'b1; c_wa = r_start;
                c_wd = '{obst: r_crd.obst, expd: 1'b0, cost: 7'd0,
                         est: est_of(r_start, 7'd0, r_goal), par: gaps_pkg::DIR_NONE};
                o_we = 1'b1; o_wa = '0; o_wd = r_start;
                n_cnt = 9'd1; n_i = 9'd1;
                n_st = (r_start == r_goal) ? gaps_pkg::ST_DUMP_R : gaps_pkg::ST_SORT_I;
                n_idx = '0;
                n_oidx = '0;
            end
            // insertion sort: i outer, v = list[i], fv = est(v)
            gaps_pkg::ST_SORT_I: begin
                if (r_i >= r_cnt) begin
                    n_k = '0; n_st = gaps_pkg::ST_SKIP_R;
                end else begin
                    o_ra = r_i[OW-1:0]; n_st = gaps_pkg::ST_SORT_RV;
                end
            end
            gaps_pkg::ST_SORT_RV: begin
                n_v = r_ord; c_ra = r_ord; n_st = gaps_pkg::ST_SORT_WV;
            end
            gaps_pkg::ST_SORT_WV: begin
                n_fv = r_crd.est; n_j = r_i; n_st = gaps_pkg::ST_SORT_RJ;
            end
            gaps_pkg::ST_SORT_RJ: begin
                if (r_j == '0) n_st = gaps_pkg::ST_SORT_PUT;
                else begin
                    o_ra = OW'(r_j - 9'd1); n_st = gaps_pkg::ST_SORT_WJ;
                end
            end
            gaps_pkg::ST_SORT_WJ: begin
                n_w = r_ord; c_ra = r_ord; n_st = gaps_pkg::ST_SORT_CMP;
            end
            gaps_pkg::ST_SORT_CMP: begin
                if (r_crd.est > r_fv) begin
                    o_we = 1'b1; o_wa = r_j[OW-1:0]; o_wd = r_w;
                    n_j = r_j - 9'd1; n_st = gaps_pkg::ST_SORT_RJ;
                end else n_st = gaps_pkg::ST_SORT_PUT;
            end
            gaps_pkg::ST_SORT_PUT: begin
                o_we = 1'b1; o_wa = r_j[OW-1:0]; o_wd = r_v;
                n_i = r_i + 9'd1; n_st = gaps_pkg::ST_SORT_I;
            end
            // count expanded cells at the head
            gaps_pkg::ST_SKIP_R: begin
                if (r_k >= r_cnt) begin
                    n_st = gaps_pkg::ST_DUMP_R;
                end else begin
                    o_ra = r_k[OW-1:0]; n_st = gaps_pkg::ST_SKIP_W;
                end
            end
            gaps_pkg::ST_SKIP_W: begin
                c_ra = r_ord; n_v = r_ord; n_st = gaps_pkg::ST_SKIP_T;
            end
            gaps_pkg::ST_SKIP_T: begin
                if (r_crd.expd) begin
                    n_k = r_k + 9'd1; n_st = gaps_pkg::ST_SKIP_R;
                end else begin
                    n_cur = r_v; n_ccost = r_crd.cost; n_j = '0;
                    if (r_k == '0) begin
                        // fetch the head cell again for the expand write
                        c_ra = r_v; n_st = gaps_pkg::ST_EXP;
                    end else n_st = gaps_pkg::ST_SH_R;
                end
            end
            // shift the list down by k
            gaps_pkg::ST_SH_R: begin
                if (r_j + r_k >= r_cnt) begin
                    n_cnt = r_cnt - r_k; c_ra = r_cur; n_st = gaps_pkg::ST_EXP;
                end else begin
                    o_ra = OW'(r_j + r_k); n_st = gaps_pkg::ST_SH_W;
                end
            end
            gaps_pkg::ST_SH_W: begin
                o_we = 1'b1; o_wa = r_j[OW-1:0]; o_wd = r_ord;
                n_j = r_j + 9'd1; n_st = gaps_pkg::ST_SH_R;
            end
            gaps_pkg::ST_EXP: begin
                c_we = 1'b1; c_wa = r_cur; c_wd = r_crd; c_wd.expd = 1'b1;
                n_d = 2'd0; n_st = gaps_pkg::ST_NB_R;
            end
            gaps_pkg::ST_NB_R: begin
                if (!nb_ok) begin
                    n_st = gaps_pkg::ST_NB_D;
                end else begin
                    c_ra = nb_c; n_nb = nb_c; n_st = gaps_pkg::ST_NB_W;
                end
            end
            gaps_pkg::ST_NB_W: begin
                if (!r_crd.expd && !r_crd.obst && (r_cnt < 9'(gaps_pkg::OPEN_DEPTH))) begin
                    o_we = 1'b1; o_wa = r_cnt[OW-1:0]; o_wd = r_nb;
                    n_cnt = r_cnt + 9'd1;
                end
                if ((r_ccost + 7'd1) < r_crd.cost) begin
                    c_we = 1'b1; c_wa = r_nb; c_wd = r_crd;
                    c_wd.cost = r_ccost + 7'd1; c_wd.par = nb_dir;
                    c_wd.est = est_of(r_nb, r_ccost + 7'd1, r_goal);
                end
                n_st = gaps_pkg::ST_NB_D;
            end
            gaps_pkg::ST_NB_D: begin
                n_d = r_d + 2'd1;
                if (r_d == 2'd3) begin
                    n_i = 9'd1;
                    n_st = (r_cur == r_goal) ? gaps_pkg::ST_DUMP_R : gaps_pkg::ST_SORT_I;
                end else n_st = gaps_pkg::ST_NB_R;
            end
            // dump x outer, y inner
            gaps_pkg::ST_DUMP_R: begin
                c_ra = {r_oidx[2:0], r_oidx[5:3]}; n_st = gaps_pkg::ST_DUMP_W;
            end
            gaps_pkg::ST_DUMP_W: begin
                n_ov = 1'b1; n_oc = r_crd; n_idx = r_oidx;
                n_oidx = r_oidx + 6'd1;
                n_st = (r_oidx == 6'd63) ? gaps_pkg::ST_IDLE : gaps_pkg::ST_DUMP_R;
            end
            default: n_st = gaps_pkg::ST_IDLE;
        endcase
    end

    assign busy = (r_st != gaps_pkg::ST_IDLE) || r_ov;
    assign o_valid = r_ov;
    assign o_cell_x = r_idx[5:3];
    assign o_cell_y = r_idx[2:0];
    assign o_is_obstacle = r_oc.obst;
    assign o_was_expanded = r_oc.expd;
    assign o_parent_dir = r_oc.par;
    assign o_has_cost = r_oc.cost != gaps_pkg::COST_INF;
    assign o_path_cost = (r_oc.cost == gaps_pkg::COST_INF) ? 6'd0 :
                         (r_oc.cost > 7'd63) ? 6'd63 : r_oc.cost[5:0];
    assign o_last = r_ov && (r_idx == 6'd63);

    a_last_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last |-> o_valid) else $error("last without valid");
    a_busy_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy) else $error("result while not busy");
    a_cnt_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == gaps_pkg::ST_NB_W) |-> (r_cnt <= 9'(gaps_pkg::OPEN_DEPTH)))
        else $error("open count overflow");

endmodule
